>>> sv/lzwc_pkg.sv
// Shared constants, types and microcode definitions for the LZW phrase counter.
`timescale 1ns / 1ps

package lzwc_pkg;

    localparam int DICT_DEPTH      = 4096;
    localparam int BYTE_CODES      = 256;
    localparam int SYMBOL_W        = 8;
    localparam int PHRASE_COUNT_W  = 13;
    localparam int IDX_W           = $clog2(DICT_DEPTH);
    localparam int CNT_W           = $clog2(DICT_DEPTH + 1);
    localparam int CODE_W          = $clog2(BYTE_CODES + DICT_DEPTH);
    localparam int ENTRY_W         = CODE_W + SYMBOL_W;

    // Datapath operation selected by the current control word.
    typedef enum logic [2:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_SCAN,
        OP_MISS,
        OP_FIRST,
        OP_EMIT
    } op_t;

    // Conditions tested by the sequencer.
    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_INPUT,
        COND_FIRST,
        COND_HIT,
        COND_BUSY,
        COND_OUT_FULL
    } cond_t;

    // Program steps.
    typedef enum logic [2:0] {
        STEP_IDLE,
        STEP_DISPATCH,
        STEP_SCAN,
        STEP_MISS,
        STEP_FIRST,
        STEP_RESULT
    } step_t;

    typedef struct packed {
        op_t   op;
        cond_t wait_cond;
        cond_t jmp_cond;
        step_t jmp_target;
    } ctrl_word_t;

    // Status flags fed back from the datapath to the sequencer.
    typedef struct packed {
        logic in_valid;
        logic first;
        logic hit;
        logic busy;
        logic out_full;
    } status_t;

    // Microcode: hold on wait_cond, else jump on jmp_cond, else advance.
    function automatic ctrl_word_t program_word(step_t step);
        ctrl_word_t w;
        w = '{op: OP_NONE, wait_cond: COND_NEVER, jmp_cond: COND_ALWAYS,
              jmp_target: STEP_IDLE};
        unique case (step)
            STEP_IDLE:
                w = '{op: OP_ACCEPT, wait_cond: COND_NO_INPUT,
                      jmp_cond: COND_NEVER, jmp_target: STEP_IDLE};
            STEP_DISPATCH:
                w = '{op: OP_NONE, wait_cond: COND_NEVER,
                      jmp_cond: COND_FIRST, jmp_target: STEP_FIRST};
            STEP_SCAN:
                w = '{op: OP_SCAN, wait_cond: COND_BUSY,
                      jmp_cond: COND_HIT, jmp_target: STEP_RESULT};
            STEP_MISS:
                w = '{op: OP_MISS, wait_cond: COND_NEVER,
                      jmp_cond: COND_ALWAYS, jmp_target: STEP_RESULT};
            STEP_FIRST:
                w = '{op: OP_FIRST, wait_cond: COND_NEVER,
                      jmp_cond: COND_NEVER, jmp_target: STEP_IDLE};
            STEP_RESULT:
                w = '{op: OP_EMIT, wait_cond: COND_OUT_FULL,
                      jmp_cond: COND_ALWAYS, jmp_target: STEP_IDLE};
            default:
                w = '{op: OP_NONE, wait_cond: COND_NEVER,
                      jmp_cond: COND_ALWAYS, jmp_target: STEP_IDLE};
        endcase
        return w;
    endfunction

endpackage

>>> sv/lzwc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module lzwc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> sv/lzwc_seq.sv
// Microcode sequencer: step register, program table and condition select.
`timescale 1ns / 1ps

module lzwc_seq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  lzwc_pkg::status_t    status,
    output lzwc_pkg::ctrl_word_t ctrl
);
    import lzwc_pkg::*;

    step_t step_reg;
    step_t step_next;
    logic  wait_hit;
    logic  jmp_hit;

    function automatic logic test_cond(cond_t c, status_t s);
        logic r;
        r = 1'b0;
        unique case (c)
            COND_NEVER:    r = 1'b0;
            COND_ALWAYS:   r = 1'b1;
            COND_NO_INPUT: r = !s.in_valid;
            COND_FIRST:    r = s.first;
            COND_HIT:      r = s.hit;
            COND_BUSY:     r = s.busy;
            COND_OUT_FULL: r = s.out_full;
            default:       r = 1'b0;
        endcase
        return r;
    endfunction

    // Output: the control word of the current step.
    always_comb
    begin
        ctrl = program_word(step_reg);
    end

    // Next step.
    always_comb
    begin
        wait_hit = test_cond(ctrl.wait_cond, status);
        jmp_hit  = test_cond(ctrl.jmp_cond, status);
        priority if (wait_hit)
        begin
            step_next = step_reg;
        end
        else if (jmp_hit)
        begin
            step_next = ctrl.jmp_target;
        end
        else
        begin
            step_next = step_t'(step_reg + 3'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

`ifndef SYNTHESIS
    a_step_in_program: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg == STEP_IDLE || step_reg == STEP_DISPATCH || step_reg == STEP_SCAN ||
        step_reg == STEP_MISS || step_reg == STEP_FIRST || step_reg == STEP_RESULT)
        else $error("sequencer left the program");
    a_result_follows_miss: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg == STEP_MISS |=> step_reg == STEP_RESULT)
        else $error("miss step not followed by result step");
    a_dispatch_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg == STEP_IDLE && status.in_valid) |=> step_reg == STEP_DISPATCH)
        else $error("accepted item not dispatched");
`endif

endmodule

>>> sv/lzwc_datapath.sv
// Datapath: current word, phrase count, scan pipeline and output register.
`timescale 1ns / 1ps

module lzwc_datapath (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  lzwc_pkg::ctrl_word_t                  ctrl,
    output lzwc_pkg::status_t                     status,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [lzwc_pkg::SYMBOL_W-1:0]         symbol,
    input  logic                                  first,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [lzwc_pkg::PHRASE_COUNT_W-1:0]   phrase_count,
    output logic                                  overflow
);
    import lzwc_pkg::*;

    logic [SYMBOL_W-1:0]       sym_reg;
    logic                      first_reg;
    logic [CODE_W-1:0]         word_reg;
    logic [CODE_W-1:0]         word_next;
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic                      ovf_reg;
    logic                      ovf_next;
    logic [CNT_W-1:0]          idx_reg;
    logic [CNT_W-1:0]          idx_next;
    logic                      cmp_vld_reg;
    logic                      cmp_vld_next;
    logic [IDX_W-1:0]          cmp_idx_reg;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic [PHRASE_COUNT_W-1:0] phrase_count_reg;
    logic                      overflow_reg;

    logic                      accept;
    logic                      issue;
    logic                      hit;
    logic                      room;
    logic                      emit;
    logic                      wr_en;
    logic [ENTRY_W-1:0]        rd_data;

    assign in_ready = (ctrl.op == OP_ACCEPT);
    assign accept   = in_valid && in_ready;
    assign issue    = idx_reg < count_reg;
    assign hit      = cmp_vld_reg && (rd_data == {word_reg, sym_reg});
    assign room     = count_reg < CNT_W'(DICT_DEPTH);
    assign emit     = (ctrl.op == OP_EMIT) && !(out_valid_reg && !out_ready);
    assign wr_en    = (ctrl.op == OP_MISS) && room;

    assign status.in_valid = in_valid;
    assign status.first    = first_reg;
    assign status.hit      = hit;
    assign status.busy     = !hit && (cmp_vld_reg || issue);
    assign status.out_full = out_valid_reg && !out_ready;

    lzwc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DICT_DEPTH)
    ) u_phrase_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data ({word_reg, sym_reg}),
        .rd_en   (ctrl.op == OP_SCAN),
        .rd_addr (idx_reg[IDX_W-1:0]),
        .rd_data (rd_data)
    );

    always_comb
    begin
        word_next    = word_reg;
        count_next   = count_reg;
        ovf_next     = ovf_reg;
        idx_next     = idx_reg;
        cmp_vld_next = cmp_vld_reg;
        unique case (ctrl.op)
            OP_ACCEPT:
            begin
                idx_next     = '0;
                cmp_vld_next = 1'b0;
            end
            OP_SCAN:
            begin
                cmp_vld_next = issue;
                if (issue)
                begin
                    idx_next = idx_reg + CNT_W'(1);
                end
                if (hit)
                begin
                    word_next = CODE_W'(BYTE_CODES) + CODE_W'(cmp_idx_reg);
                end
            end
            OP_MISS:
            begin
                if (room)
                begin
                    count_next = count_reg + CNT_W'(1);
                end
                else
                begin
                    ovf_next = 1'b1;
                end
                word_next = CODE_W'(sym_reg);
            end
            OP_FIRST:
            begin
                count_next = '0;
                ovf_next   = 1'b0;
                word_next  = CODE_W'(sym_reg);
            end
            OP_NONE, OP_EMIT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        priority if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg      <= '0;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            idx_reg       <= '0;
            cmp_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            word_reg      <= word_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            idx_reg       <= idx_next;
            cmp_vld_reg   <= cmp_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sym_reg   <= symbol;
            first_reg <= first;
        end
        if (ctrl.op == OP_SCAN)
        begin
            cmp_idx_reg <= idx_reg[IDX_W-1:0];
        end
        if (emit)
        begin
            phrase_count_reg <= PHRASE_COUNT_W'(count_reg);
            overflow_reg     <= ovf_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign phrase_count = phrase_count_reg;
    assign overflow     = overflow_reg;

`ifndef SYNTHESIS
    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DICT_DEPTH))
        else $error("phrase count beyond table depth");
    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= count_reg)
        else $error("scan index beyond stored phrases");
    a_compare_valid_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (cmp_vld_reg && ctrl.op == OP_SCAN) |-> (CNT_W'(cmp_idx_reg) < count_reg))
        else $error("compare on an unwritten entry");
    a_overflow_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> (count_reg == CNT_W'(DICT_DEPTH)))
        else $error("overflow set while table has room");
`endif

endmodule

>>> sv/lzw_phrase_counter.sv
// Top level of the LZW phrase counter: sequencer plus datapath.
`timescale 1ns / 1ps

// LZW phrase counter. Each accepted item carries one byte of a string; the block
// extends its current word by that byte and searches the dictionary of stored
// (prefix code, byte) phrases. A found phrase becomes the current word; a missing
// one is stored (if the table has room) and the word restarts at the byte. Every
// item yields exactly one result item with the running phrase count and a sticky
// overflow flag that sets once a phrase could not be stored in the full table.
// An item with first set starts a new string: count, flag and table contents are
// dropped and the word becomes that byte. After reset the word is the byte zero.
// Search: the linear dictionary scan reads one entry per cycle through the
// single read port of the phrase RAM and covers the phrases already stored
// (at most DICT_DEPTH = 4096); a hit ends the scan early. The result sits in an
// output register, so a new item is taken while the previous result waits; the
// block holds its last step until the output register is free. The table needs
// no clearing pass: only entries below the phrase count are ever compared.

module lzw_phrase_counter (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [lzwc_pkg::SYMBOL_W-1:0]       symbol,
    input  logic                                first,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [lzwc_pkg::PHRASE_COUNT_W-1:0] phrase_count,
    output logic                                overflow
);
    import lzwc_pkg::*;

    ctrl_word_t ctrl;
    status_t    status;

    // Sequencer walks the microcode program and picks the datapath operation.
    lzwc_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    // Datapath holds the word, count, scan pipeline, phrase RAM and result.
    lzwc_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .status       (status),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .symbol       (symbol),
        .first        (first),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .phrase_count (phrase_count),
        .overflow     (overflow)
    );

endmodule

>>> sim/lzw_phrase_counter_checker.sv
// Channel monitor with a phrase-count predictor and result comparison for the LZW phrase counter.
`timescale 1ns / 1ps

module lzw_phrase_counter_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  logic [lzwc_pkg::SYMBOL_W-1:0]       symbol,
    input  logic                                first,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic [lzwc_pkg::PHRASE_COUNT_W-1:0] phrase_count,
    input  logic                                overflow,
    output int                                  error_count,
    output int                                  pending
);
    import lzwc_pkg::*;

    typedef struct packed {
        logic [PHRASE_COUNT_W-1:0] phrase_count;
        logic                      overflow;
    } count_report_t;

    // Predicted dictionary: (prefix code, byte) per stored phrase.
    logic [CODE_W-1:0]   dict_prefix [DICT_DEPTH];
    logic [SYMBOL_W-1:0] dict_byte   [DICT_DEPTH];
    logic [CODE_W-1:0]   word_code      = '0;
    int                  stored_phrases = 0;
    logic                table_full_hit = 1'b0;
    int                  mismatches     = 0;
    count_report_t       count_reports_q [$];

    // Index of the stored phrase (prefix, sym), or -1 when absent.
    function automatic int find_phrase(input logic [CODE_W-1:0] prefix,
                                       input logic [SYMBOL_W-1:0] sym);
        int i;
        for (i = 0; i < stored_phrases; i++)
        begin
            if (dict_prefix[i] == prefix && dict_byte[i] == sym)
                return i;
        end
        return -1;
    endfunction

    // Advance the predicted dictionary by one byte and report the new count.
    task automatic absorb_symbol(input logic [SYMBOL_W-1:0] sym, input logic restart,
                                 output count_report_t rep);
        int hit;
        if (restart)
        begin
            stored_phrases = 0;
            table_full_hit = 1'b0;
            word_code      = CODE_W'(sym);
        end
        else
        begin
            hit = find_phrase(word_code, sym);
            if (hit >= 0)
                word_code = CODE_W'(BYTE_CODES + hit);
            else
            begin
                if (stored_phrases < DICT_DEPTH)
                begin
                    dict_prefix[stored_phrases] = word_code;
                    dict_byte[stored_phrases]   = sym;
                    stored_phrases++;
                end
                else
                    table_full_hit = 1'b1;
                word_code = CODE_W'(sym);
            end
        end
        rep.phrase_count = PHRASE_COUNT_W'(stored_phrases);
        rep.overflow     = table_full_hit;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        count_report_t want;
        count_report_t seen;
        if (!rst_n)
        begin
            word_code      = '0;
            stored_phrases = 0;
            table_full_hit = 1'b0;
            count_reports_q.delete();
            pending <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                absorb_symbol(symbol, first, want);
                count_reports_q.push_back(want);
            end
            if (out_valid && out_ready)
            begin
                seen.phrase_count = phrase_count;
                seen.overflow     = overflow;
                if (count_reports_q.size() == 0)
                begin
                    $error("unexpected result item: phrase_count %0d overflow %0b",
                           seen.phrase_count, seen.overflow);
                    mismatches++;
                end
                else
                begin
                    want = count_reports_q.pop_front();
                    if (seen.phrase_count !== want.phrase_count)
                    begin
                        $error("phrase_count: expected %0d, got %0d",
                               want.phrase_count, seen.phrase_count);
                        mismatches++;
                    end
                    if (seen.overflow !== want.overflow)
                    begin
                        $error("overflow: expected %0b, got %0b", want.overflow, seen.overflow);
                        mismatches++;
                    end
                end
            end
            pending <= count_reports_q.size();
        end
        error_count <= mismatches;
    end

endmodule

>>> sim/lzw_phrase_counter_tb.sv
// Top-level testbench for the LZW phrase counter: stimulus, handshake pressure and verdict.
`timescale 1ns / 1ps

module lzw_phrase_counter_tb;
    import lzwc_pkg::*;

    // Receiver hold-off long enough for the block to fill its output register
    // and stall its input while the sender keeps offering items.
    localparam int HOLD_CYCLES    = 400;
    // Slowest item is a full miss scan over the whole dictionary; keep a wide margin.
    localparam int CYCLE_LIMIT    = 20000;
    localparam int SETTLE_CYCLES  = 20;

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      in_valid  = 1'b0;
    logic                      in_ready;
    logic [SYMBOL_W-1:0]       symbol    = '0;
    logic                      first     = 1'b0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic [PHRASE_COUNT_W-1:0] phrase_count;
    logic                      overflow;

    int error_count;
    int pending;

    // Idle rates in percent; stimulus changes them between phases.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // Long hold-off requests, served by the receiver process.
    int stall_requests = 0;

    // Per-string alphabet for random stimulus: a narrow alphabet makes the
    // dictionary hit often and grow long phrases, span 255 is plain noise.
    int alpha_base = 0;
    int alpha_span = 255;

    int   quiet_cycles    = 0;

    always #1 clk = ~clk;

    lzw_phrase_counter dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .symbol       (symbol),
        .first        (first),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .phrase_count (phrase_count),
        .overflow     (overflow)
    );

    lzw_phrase_counter_checker count_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .symbol       (symbol),
        .first        (first),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .phrase_count (phrase_count),
        .overflow     (overflow),
        .error_count  (error_count),
        .pending      (pending)
    );

    // Receiver: serve a pending long hold-off first, else drop ready at the
    // current idle rate. Drive at the falling edge only.
    always @(negedge clk)
    begin
        int hold_left;
        int stall_served;
        if (stall_served != stall_requests)
        begin
            stall_served = stall_requests;
            hold_left    = HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Watchdog: end the run when nothing moves on either channel for too long.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= CYCLE_LIMIT)
        begin
            $display("lzw_phrase_counter_tb: errors");
            $finish;
        end
    end

    // Offer one item, called at a falling edge. Idle first at the sender's
    // rate, then hold valid and payload until the item is accepted. Valid is
    // only lowered inside the idle loop, so it never drops and rises in one step.
    task automatic send_item(input logic [SYMBOL_W-1:0] sym, input logic restart);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        symbol   <= sym;
        first    <= restart;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Hold the sender off until every expected result has arrived.
    task automatic pause_until_drained();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
    endtask

    // Random strings: mostly narrow alphabets for deep phrase chains,
    // occasional restarts and full-range bytes.
    task automatic random_items(input int count);
        int          i;
        logic        restart;
        logic [SYMBOL_W-1:0] sym;
        for (i = 0; i < count; i++)
        begin
            restart = ($urandom_range(0, 99) < 8);
            if (restart)
            begin
                alpha_base = $urandom_range(0, 255);
                alpha_span = ($urandom_range(0, 3) == 0) ? 255 : $urandom_range(1, 3);
            end
            sym = SYMBOL_W'(alpha_base + $urandom_range(0, alpha_span));
            send_item(sym, restart);
        end
    endtask

    initial
    begin
        int i;

        // Hold reset, then release it at a falling edge.
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Phase A: sender idles lightly, receiver heavily.
        send_idle_pct = 33;
        recv_idle_pct = 80;

        // A byte with no prior first: the word starts as byte zero, so the
        // first zero byte already forms the pair (0, 0).
        send_item(8'h00, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'hFF, 1'b0);
        // Restart on an all-ones byte: count and flag clear, nothing stored.
        send_item(8'hFF, 1'b1);
        send_item(8'hFF, 1'b0);
        // Alternating pattern grows phrases through repeated hits.
        send_item(8'hAA, 1'b1);
        for (i = 0; i < 10; i++)
            send_item((i % 2 == 0) ? 8'h55 : 8'hAA, 1'b0);
        send_item(8'h0F, 1'b0);
        send_item(8'hF0, 1'b0);
        send_item(8'h00, 1'b1);
        send_item(8'h80, 1'b0);
        send_item(8'h01, 1'b0);

        // Long receiver hold-off while items keep coming: fill the block up
        // so its input stalls, then let everything drain.
        stall_requests <= stall_requests + 1;
        alpha_base = 8'h30;
        alpha_span = 2;
        random_items(10);
        pause_until_drained();

        random_items(30);

        // Phase B: sender idles heavily, receiver lightly.
        send_idle_pct = 80;
        recv_idle_pct = 33;
        random_items(35);

        // Phase C: no idling on either side.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_items(40);

        // Restart with random bytes, then a short tail on the new string.
        send_item(SYMBOL_W'($urandom_range(0, 255)), 1'b1);
        send_item(SYMBOL_W'($urandom_range(0, 255)), 1'b0);
        send_item(SYMBOL_W'($urandom_range(0, 255)), 1'b0);

        // Drain, then keep watching for stray results before the verdict.
        pause_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (error_count == 0 && pending == 0)
            $display("lzw_phrase_counter_tb: clean");
        else
            $display("lzw_phrase_counter_tb: errors");
        $finish;
    end

endmodule

>>> files.f
sv/lzwc_pkg.sv
sv/lzwc_ram.sv
sv/lzwc_seq.sv
sv/lzwc_datapath.sv
sv/lzw_phrase_counter.sv
sim/lzw_phrase_counter_checker.sv
sim/lzw_phrase_counter_tb.sv
